[rtl/nstp_pkg.sv]
// ----------------------------------------------------------------------------
// nstp_pkg
// Shared types and codes of the nested scope time profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package nstp_pkg;

	localparam logic [1:0] KIND_BEGIN = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_COUNT = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam logic [0:0] REG_ENABLE = 1'b0;

	typedef struct packed {
		logic [3:0]  phase;
		logic [63:0] wall_start;
		logic [63:0] cpu_start;
		logic [63:0] child_time;
	} frame_t;

	typedef struct packed {
		logic [63:0] total;
		logic [63:0] self_time;
		logic [63:0] cpu;
		logic [31:0] calls;
	} acc_t;

endpackage

`default_nettype wire

[rtl/nstp_frame_mem.sv]
// ----------------------------------------------------------------------------
// nstp_frame_mem
// Scope stack frame store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module nstp_frame_mem
	import nstp_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          re,
	input  wire logic [AW-1:0] addr_a,
	input  wire logic [AW-1:0] addr_b,
	output frame_t             rdata_a,
	output frame_t             rdata_b,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire frame_t        wdata
);

	frame_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[addr_a];
			rdata_b <= mem[addr_b];
		end
	end

endmodule

`default_nettype wire

[rtl/nstp_acc_mem.sv]
// ----------------------------------------------------------------------------
// nstp_acc_mem
// Per-phase accumulator store with valid bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module nstp_acc_mem
	import nstp_pkg::*;
#(
	parameter int DEPTH = 11,
	parameter int PW    = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          re,
	input  wire logic [PW-1:0] raddr,
	output acc_t               rdata,
	input  wire logic          we,
	input  wire logic [PW-1:0] waddr,
	input  wire acc_t          wdata
);

	acc_t             mem [DEPTH];
	acc_t             rd_q;
	logic             rd_vld_q;
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

[rtl/nested_scope_time_profiler_top.sv]
// Begin, count and ignored end requests give their result in the cycle after
//   acceptance; a read passes through S_READ, and a recorded end runs the
//   frame read, accumulator read and write-back sequence through S_E1, S_E2
//   and S_E3. busy drops in the result cycle, so the next request may follow
//   at once; busy holds off new requests while a read or end is in flight.
// Reset: arst_n clears depth, overflow, enable, counters and accumulator
//   valid bits at once; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
// nested_scope_time_profiler_top
// Profiler for nested timed regions: frame stack, phase accumulators and
// event counters, with an APB register for enable.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_scope_time_profiler_top
	import nstp_pkg::*;
#(
	parameter int STACK_DEPTH  = 64,
	parameter int NUM_PHASES   = 11,
	parameter int NUM_COUNTERS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  phase,
	input  wire logic [6:0]  token,
	input  wire logic [63:0] wall_time,
	input  wire logic [63:0] cpu_time,
	input  wire logic [2:0]  counter_index,
	input  wire logic [63:0] amount,
	output logic             done,
	output logic      [6:0]  new_token,
	output logic      [63:0] phase_total,
	output logic      [63:0] phase_self,
	output logic      [63:0] phase_cpu,
	output logic      [31:0] phase_calls,
	output logic      [63:0] counter_value,
	output logic             overflowed,
	output logic      [6:0]  open_scopes
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int TW = (DW > 7) ? DW : 7;
	localparam int PW = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
	localparam int CW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_E1,
		S_E2,
		S_E3
	} state_t;

	state_t          state_q;
	logic            enable_q;
	logic [DW-1:0]   depth_q;
	logic            ovf_q;
	logic [63:0]     cnt_q [NUM_COUNTERS];

	logic [63:0]     wall_q;
	logic [63:0]     cpu_q;
	logic            rd_ph_ok_q;
	logic            rd_c_ok_q;
	logic [CW-1:0]   cidx_q;
	logic            par_q;
	logic [AW-1:0]   pa_q;

	logic [63:0]     dt_s1;
	logic [63:0]     cdt_s1;
	logic [63:0]     ch_s1;
	frame_t          pfrm_s1;
	logic [PW-1:0]   p_s1;
	logic            pok_s1;
	logic [63:0]     self_s2;

	frame_t          frm_a;
	frame_t          frm_b;
	frame_t          fw_data;
	logic            fw_en;
	logic [AW-1:0]   fw_addr;
	acc_t            acc_rd;
	acc_t            acc_wr;
	logic            acc_re;
	logic [PW-1:0]   acc_raddr;
	logic            acc_we;

	logic            req;
	logic [TW-1:0]   tok_tw;
	logic [TW-1:0]   dep_tw;
	logic [TW-1:0]   tok_m1;
	logic [TW-1:0]   tok_m2;
	logic [TW-1:0]   dep_nx_tw;
	logic            end_ok;
	logic            ph_ok;
	logic            c_ok;
	logic            full;
	logic            beg_act;
	logic            push;
	logic            ovf_nx;
	logic [DW-1:0]   depth_nx;
	logic            apb_wr;

	// APB register
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;
	assign prdata = (paddr[2:2] == REG_ENABLE) ? {31'd0, enable_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (apb_wr && paddr[2:2] == REG_ENABLE) begin
			enable_q <= pwdata[0];
		end
	end

	// request decode
	assign busy     = (state_q != S_IDLE);
	assign req      = start && !busy;
	assign tok_tw   = TW'(token);
	assign dep_tw   = TW'(depth_q);
	assign tok_m1   = tok_tw - TW'(1);
	assign tok_m2   = tok_tw - TW'(2);
	assign end_ok   = enable_q && (tok_tw != '0) && (tok_tw <= dep_tw);
	assign ph_ok    = {1'b0, phase} < 5'(NUM_PHASES);
	assign c_ok     = {1'b0, counter_index} < 4'(NUM_COUNTERS);
	assign full     = depth_q >= DW'(STACK_DEPTH);
	assign beg_act  = req && (kind == KIND_BEGIN) && enable_q && ph_ok;
	assign push     = beg_act && !full;
	assign ovf_nx   = ovf_q || (beg_act && full);

	always_comb begin
		depth_nx = depth_q;
		if (push) begin
			depth_nx = depth_q + DW'(1);
		end else if (req && kind == KIND_END && end_ok) begin
			depth_nx = tok_m1[DW-1:0];
		end
	end

	assign dep_nx_tw = TW'(depth_nx);

	// frame store
	assign fw_en   = push || (state_q == S_E2 && par_q);
	assign fw_addr = (state_q == S_E2) ? pa_q : depth_q[AW-1:0];

	always_comb begin
		if (state_q == S_E2) begin
			fw_data            = pfrm_s1;
			fw_data.child_time = pfrm_s1.child_time + dt_s1;
		end else begin
			fw_data.phase      = phase;
			fw_data.wall_start = wall_time;
			fw_data.cpu_start  = cpu_time;
			fw_data.child_time = 64'd0;
		end
	end

	nstp_frame_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_frame_mem (
		.clk     (clk),
		.re      (req),
		.addr_a  (tok_m1[AW-1:0]),
		.addr_b  (tok_m2[AW-1:0]),
		.rdata_a (frm_a),
		.rdata_b (frm_b),
		.we      (fw_en),
		.waddr   (fw_addr),
		.wdata   (fw_data)
	);

	// accumulator store
	assign acc_re    = (req && kind == KIND_READ) || (state_q == S_E1);
	assign acc_raddr = (state_q == S_E1) ? frm_a.phase[PW-1:0] : phase[PW-1:0];
	assign acc_we    = (state_q == S_E3) && pok_s1;

	always_comb begin
		acc_wr.total     = acc_rd.total + dt_s1;
		acc_wr.self_time = acc_rd.self_time + self_s2;
		acc_wr.cpu       = acc_rd.cpu + cdt_s1;
		acc_wr.calls     = acc_rd.calls + 32'd1;
	end

	nstp_acc_mem #(
		.DEPTH (NUM_PHASES),
		.PW    (PW)
	) u_acc_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (acc_re),
		.raddr  (acc_raddr),
		.rdata  (acc_rd),
		.we     (acc_we),
		.waddr  (p_s1),
		.wdata  (acc_wr)
	);

	// event counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				cnt_q[i] <= 64'd0;
			end
		end else if (req && kind == KIND_COUNT && enable_q && c_ok) begin
			cnt_q[counter_index[CW-1:0]] <= cnt_q[counter_index[CW-1:0]] + amount;
		end
	end

	// request payload and end pipeline
	always_ff @(posedge clk) begin
		if (req) begin
			wall_q     <= wall_time;
			cpu_q      <= cpu_time;
			rd_ph_ok_q <= ph_ok;
			rd_c_ok_q  <= c_ok;
			cidx_q     <= counter_index[CW-1:0];
			par_q      <= tok_tw >= TW'(2);
			pa_q       <= tok_m2[AW-1:0];
		end
		if (state_q == S_E1) begin
			dt_s1   <= (wall_q > frm_a.wall_start) ? wall_q - frm_a.wall_start : 64'd0;
			cdt_s1  <= (cpu_q > frm_a.cpu_start) ? cpu_q - frm_a.cpu_start : 64'd0;
			ch_s1   <= frm_a.child_time;
			pfrm_s1 <= frm_b;
			p_s1    <= frm_a.phase[PW-1:0];
			pok_s1  <= {1'b0, frm_a.phase} < 5'(NUM_PHASES);
		end
		if (state_q == S_E2) begin
			self_s2 <= (dt_s1 > ch_s1) ? dt_s1 - ch_s1 : 64'd0;
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			depth_q       <= '0;
			ovf_q         <= 1'b0;
			done          <= 1'b0;
			new_token     <= 7'd0;
			phase_total   <= 64'd0;
			phase_self    <= 64'd0;
			phase_cpu     <= 64'd0;
			phase_calls   <= 32'd0;
			counter_value <= 64'd0;
			overflowed    <= 1'b0;
			open_scopes   <= 7'd0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req) begin
						depth_q       <= depth_nx;
						ovf_q         <= ovf_nx;
						new_token     <= push ? dep_nx_tw[6:0] : 7'd0;
						phase_total   <= 64'd0;
						phase_self    <= 64'd0;
						phase_cpu     <= 64'd0;
						phase_calls   <= 32'd0;
						counter_value <= 64'd0;
						overflowed    <= ovf_nx;
						open_scopes   <= dep_nx_tw[6:0];
						if (kind == KIND_READ) begin
							state_q <= S_READ;
						end else if (kind == KIND_END && end_ok) begin
							state_q <= S_E1;
						end else begin
							done <= 1'b1;
						end
					end
				end
				S_READ: begin
					done          <= 1'b1;
					phase_total   <= rd_ph_ok_q ? acc_rd.total : 64'd0;
					phase_self    <= rd_ph_ok_q ? acc_rd.self_time : 64'd0;
					phase_cpu     <= rd_ph_ok_q ? acc_rd.cpu : 64'd0;
					phase_calls   <= rd_ph_ok_q ? acc_rd.calls : 32'd0;
					counter_value <= rd_c_ok_q ? cnt_q[cidx_q] : 64'd0;
					state_q       <= S_IDLE;
				end
				S_E1: begin
					state_q <= S_E2;
				end
				S_E2: begin
					state_q <= S_E3;
				end
				S_E3: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/nstp_checker.sv]
// ----------------------------------------------------------------------------
// nstp_checker
// Port-level checks of the profiler request and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module nstp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [6:0] new_token,
	input wire logic [6:0] open_scopes,
	input wire logic       overflowed
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_req_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted request neither finished nor in progress");

	a_token_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done && new_token != 7'd0) |-> (open_scopes == new_token))
		else $error("begin token does not match stack depth");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(overflowed))
		else $error("overflow flag cleared");

endmodule

bind nested_scope_time_profiler_top nstp_checker u_nstp_checker (.*);

`default_nettype wire

[bench/nested_scope_time_profiler_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_scope_time_profiler_top_test
// Self-checking bench for the scope profiler. It drives begin, end, count and
// read requests through the start/busy handshake. The enable register is set
// over APB. Every done strobe is compared, field by field, with a prediction
// kept alongside: frame stack, phase accumulators and event counters.
// ----------------------------------------------------------------------------

module nested_scope_time_profiler_top_test;
	import nstp_pkg::*;

	localparam int STACK_DEPTH  = 64;
	localparam int NUM_PHASES   = 11;
	localparam int NUM_COUNTERS = 8;
	localparam int IDLE_LIMIT   = 5000;
	localparam logic [2:0] ADDR_ENABLE = 3'(4 * REG_ENABLE);

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  phase;
		logic [6:0]  token;
		logic [63:0] wall;
		logic [63:0] cpu;
		logic [2:0]  cidx;
		logic [63:0] amount;
	} scope_request_t;

	typedef struct packed {
		logic [6:0]  new_token;
		logic [63:0] total;
		logic [63:0] self_time;
		logic [63:0] cpu;
		logic [31:0] calls;
		logic [63:0] count;
		logic        ovf;
		logic [6:0]  open;
	} profile_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [3:0]  phase;
	logic [6:0]  token;
	logic [63:0] wall_time, cpu_time;
	logic [2:0]  counter_index;
	logic [63:0] amount;
	logic        done;
	logic [6:0]  new_token;
	logic [63:0] phase_total, phase_self, phase_cpu;
	logic [31:0] phase_calls;
	logic [63:0] counter_value;
	logic        overflowed;
	logic [6:0]  open_scopes;

	// predicted block state
	logic        enabled = 1'b0;
	logic [3:0]  stk_phase [STACK_DEPTH];
	logic [63:0] stk_wall  [STACK_DEPTH];
	logic [63:0] stk_cpu   [STACK_DEPTH];
	logic [63:0] stk_child [STACK_DEPTH];
	int unsigned depth = 0;
	logic        ovf_flag = 1'b0;
	logic [63:0] acc_total [NUM_PHASES] = '{default: '0};
	logic [63:0] acc_self  [NUM_PHASES] = '{default: '0};
	logic [63:0] acc_cpu   [NUM_PHASES] = '{default: '0};
	logic [31:0] acc_calls [NUM_PHASES] = '{default: '0};
	logic [63:0] evt_count [NUM_COUNTERS] = '{default: '0};

	profile_result_t pending_results[$];
	bit          gaps_on = 1'b1;
	logic [63:0] wall_now, cpu_now;
	int          mismatches = 0;
	int          results_checked = 0;
	int          requests_sent = 0;
	int          begins_recorded = 0, ends_recorded = 0, counts_done = 0, reads_done = 0;
	int          idle_cycles = 0;

	nested_scope_time_profiler_top #(
		.STACK_DEPTH(STACK_DEPTH),
		.NUM_PHASES(NUM_PHASES),
		.NUM_COUNTERS(NUM_COUNTERS)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.kind(kind), .phase(phase), .token(token), .wall_time(wall_time),
		.cpu_time(cpu_time), .counter_index(counter_index), .amount(amount),
		.done(done), .new_token(new_token), .phase_total(phase_total),
		.phase_self(phase_self), .phase_cpu(phase_cpu), .phase_calls(phase_calls),
		.counter_value(counter_value), .overflowed(overflowed),
		.open_scopes(open_scopes)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] span(logic [63:0] now, logic [63:0] since);
		return (now > since) ? now - since : 64'd0;
	endfunction

	function automatic scope_request_t make_request(logic [1:0] k, logic [3:0] ph,
			logic [6:0] tk, logic [63:0] wt, logic [63:0] ct, logic [2:0] ci,
			logic [63:0] am);
		scope_request_t rq;
		rq = '{kind: k, phase: ph, token: tk, wall: wt, cpu: ct, cidx: ci, amount: am};
		return rq;
	endfunction

	function automatic profile_result_t predict_profile(scope_request_t rq);
		profile_result_t r;
		int unsigned d;
		logic [3:0] p;
		logic [63:0] dt;
		r = '0;
		case (rq.kind)
			KIND_BEGIN: begin
				if (enabled && rq.phase < NUM_PHASES) begin
					if (depth >= STACK_DEPTH) begin
						ovf_flag = 1'b1;
					end else begin
						stk_phase[depth] = rq.phase;
						stk_wall[depth] = rq.wall;
						stk_cpu[depth] = rq.cpu;
						stk_child[depth] = '0;
						depth++;
						r.new_token = 7'(depth);
						begins_recorded++;
					end
				end
			end
			KIND_END: begin
				if (enabled && rq.token != 0 && rq.token <= depth) begin
					d = rq.token - 1;
					p = stk_phase[d];
					dt = span(rq.wall, stk_wall[d]);
					depth = d;
					acc_total[p] += dt;
					acc_self[p] += (dt > stk_child[d]) ? dt - stk_child[d] : 64'd0;
					acc_cpu[p] += span(rq.cpu, stk_cpu[d]);
					acc_calls[p] += 32'd1;
					if (d > 0)
						stk_child[d - 1] += dt;
					ends_recorded++;
				end
			end
			KIND_COUNT: begin
				if (enabled && rq.cidx < NUM_COUNTERS) begin
					evt_count[rq.cidx] += rq.amount;
					counts_done++;
				end
			end
			KIND_READ: begin
				if (rq.phase < NUM_PHASES) begin
					r.total = acc_total[rq.phase];
					r.self_time = acc_self[rq.phase];
					r.cpu = acc_cpu[rq.phase];
					r.calls = acc_calls[rq.phase];
				end
				if (rq.cidx < NUM_COUNTERS)
					r.count = evt_count[rq.cidx];
				reads_done++;
			end
			default: begin
			end
		endcase
		r.ovf = ovf_flag;
		r.open = 7'(depth);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
	endtask

	task automatic send_request(input scope_request_t rq);
		@(negedge clk);
		if (gaps_on && $urandom_range(99) < 18) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		kind <= rq.kind;
		phase <= rq.phase;
		token <= rq.token;
		wall_time <= rq.wall;
		cpu_time <= rq.cpu;
		counter_index <= rq.cidx;
		amount <= rq.amount;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_profile(rq));
		requests_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_ENABLE)
			enabled = value[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_enable_readback();
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_ENABLE;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== {31'b0, enabled})
			report_mismatch("enable readback", 64'(got), 64'(enabled));
	endtask

	task automatic run_random_traffic(input int target, input bit with_gaps);
		scope_request_t rq;
		int unsigned r, t;
		int base;
		gaps_on = with_gaps;
		base = begins_recorded + ends_recorded + counts_done + reads_done;
		while (begins_recorded + ends_recorded + counts_done + reads_done - base < target) begin
			wall_now += $urandom_range(0, 3000);
			cpu_now += $urandom_range(0, 2000);
			rq = make_request(KIND_READ, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
				wall_now, cpu_now, 3'($urandom_range(0, 7)), 64'($urandom_range(0, 1000)));
			if ($urandom_range(99) < 4) begin
				rq.wall = rand64();
				rq.cpu = rand64();
			end
			r = $urandom_range(99);
			if (r < ((depth > 48) ? 25 : 42)) begin
				rq.kind = KIND_BEGIN;
				rq.phase = ($urandom_range(9) == 0) ? 4'($urandom_range(11, 15))
					: 4'($urandom_range(0, 10));
			end else if (r < 72) begin
				rq.kind = KIND_END;
				t = $urandom_range(99);
				if (depth != 0 && t < 70)
					rq.token = 7'(depth);
				else if (depth != 0 && t < 85)
					rq.token = 7'($urandom_range(1, depth));
			end else if (r < 86) begin
				rq.kind = KIND_COUNT;
				if ($urandom_range(1))
					rq.amount = rand64();
			end
			if ($urandom_range(199) == 0)
				drain_results();
			send_request(rq);
		end
	endtask

	task automatic test_register_access();
		check_enable_readback();
		send_request(make_request(KIND_BEGIN, 4'd1, '0, 64'd10, 64'd10, '0, '0));
		send_request(make_request(KIND_END, 4'd1, 7'd1, 64'd20, 64'd20, '0, '0));
		send_request(make_request(KIND_COUNT, '0, '0, '0, '0, 3'd2, 64'd5));
		send_request(make_request(KIND_READ, 4'd1, '0, '0, '0, 3'd2, '0));
		drain_results();
		write_register(ADDR_ENABLE, 32'd1);
		check_enable_readback();
	endtask

	task automatic test_directed_scopes();
		logic [63:0] ones;
		ones = '1;
		send_request(make_request(KIND_BEGIN, 4'd0, '0, 64'd100, 64'd50, '0, '0));
		send_request(make_request(KIND_BEGIN, 4'd10, '0, 64'd200, 64'd60, '0, '0));
		send_request(make_request(KIND_BEGIN, 4'd11, '0, 64'd210, 64'd60, '0, '0));
		send_request(make_request(KIND_BEGIN, 4'd15, '0, 64'd220, 64'd60, '0, '0));
		send_request(make_request(KIND_BEGIN, 4'd5, '0, 64'd300, 64'd70, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd0, 64'd400, 64'd80, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd127, 64'd400, 64'd80, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd4, 64'd400, 64'd80, '0, '0));
		// unwinds the phase 10 frame, cpu clock behind its start
		send_request(make_request(KIND_END, '0, 7'd2, 64'd1000, 64'd40, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd1, 64'd50, 64'd900, '0, '0));
		// child longer than parent: self time clamps
		send_request(make_request(KIND_BEGIN, 4'd1, '0, 64'd100, 64'd0, '0, '0));
		send_request(make_request(KIND_BEGIN, 4'd2, '0, 64'd100, 64'd0, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd2, 64'd1000, 64'd10, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd1, 64'd500, 64'd20, '0, '0));
		// full-range spans, twice, so the accumulators wrap
		send_request(make_request(KIND_BEGIN, 4'd3, '0, '0, '0, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd1, ones, ones, '0, '0));
		send_request(make_request(KIND_BEGIN, 4'd3, '0, '0, '0, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd1, ones, ones, '0, '0));
		send_request(make_request(KIND_COUNT, '0, '0, '0, '0, 3'd0, ones));
		send_request(make_request(KIND_COUNT, '0, '0, '0, '0, 3'd0, ones));
		send_request(make_request(KIND_COUNT, '0, '0, '0, '0, 3'd7, 64'd1));
		send_request(make_request(KIND_READ, 4'd3, '1, ones, ones, 3'd0, ones));
		send_request(make_request(KIND_READ, 4'd10, '0, '0, '0, 3'd7, '0));
		send_request(make_request(KIND_READ, 4'd15, '0, '0, '0, 3'd0, '0));
		send_request(make_request(KIND_READ, 4'd1, '0, '0, '0, 3'd7, '0));
	endtask

	task automatic test_stack_overflow();
		logic [63:0] t;
		t = 64'd5000;
		while (depth < STACK_DEPTH) begin
			t += 7;
			send_request(make_request(KIND_BEGIN, 4'($urandom_range(0, 10)), '0, t, t, '0, '0));
		end
		send_request(make_request(KIND_BEGIN, 4'd4, '0, t + 1, t, '0, '0));
		send_request(make_request(KIND_BEGIN, 4'd0, '0, t + 2, t, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd64, t + 50, t + 50, '0, '0));
		send_request(make_request(KIND_END, '0, 7'd1, t + 90, t + 90, '0, '0));
		send_request(make_request(KIND_READ, 4'd4, '0, '0, '0, 3'd1, '0));
	endtask

	task automatic test_random_traffic();
		wall_now = rand64() >> 2;
		cpu_now = rand64() >> 2;
		run_random_traffic(600, 1'b1);
		drain_results();
		write_register(ADDR_ENABLE, 32'd0);
		check_enable_readback();
		run_random_traffic(10, 1'b1);
		drain_results();
		write_register(ADDR_ENABLE, 32'd1);
		check_enable_readback();
		run_random_traffic(500, 1'b0);
		run_random_traffic(600, 1'b1);
	endtask

	task automatic test_accumulator_readout();
		for (int i = 0; i < 16; i++)
			send_request(make_request(KIND_READ, 4'(i), '0, '0, '0, 3'(i), '0));
	endtask

	always @(posedge clk) begin
		profile_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", '0, '0);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (new_token !== want.new_token)
					report_mismatch("new_token", 64'(new_token), 64'(want.new_token));
				if (phase_total !== want.total)
					report_mismatch("phase_total", phase_total, want.total);
				if (phase_self !== want.self_time)
					report_mismatch("phase_self", phase_self, want.self_time);
				if (phase_cpu !== want.cpu)
					report_mismatch("phase_cpu", phase_cpu, want.cpu);
				if (phase_calls !== want.calls)
					report_mismatch("phase_calls", 64'(phase_calls), 64'(want.calls));
				if (counter_value !== want.count)
					report_mismatch("counter_value", counter_value, want.count);
				if (overflowed !== want.ovf)
					report_mismatch("overflowed", 64'(overflowed), 64'(want.ovf));
				if (open_scopes !== want.open)
					report_mismatch("open_scopes", 64'(open_scopes), 64'(want.open));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("timeout: no request or result for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		kind = KIND_BEGIN;
		phase = '0;
		token = '0;
		wall_time = '0;
		cpu_time = '0;
		counter_index = '0;
		amount = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_access();
		test_directed_scopes();
		test_stack_overflow();
		test_random_traffic();
		test_accumulator_readout();

		drain_results();
		repeat (10) @(posedge clk);
		$display("ran %0d requests: %0d scopes opened, %0d closed, %0d counts, %0d reads",
			requests_sent, begins_recorded, ends_recorded, counts_done, reads_done);
		$display("%0d results checked, stack overflow seen: %0d, %0d mismatches",
			results_checked, ovf_flag, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
rtl/nstp_pkg.sv
rtl/nstp_frame_mem.sv
rtl/nstp_acc_mem.sv
rtl/nested_scope_time_profiler_top.sv
rtl/nstp_checker.sv
bench/nested_scope_time_profiler_top_test.sv
